### hw/rtl/signature_rrip_replacement_streaming_top_assert.svh
// Assertion macros shared by the replacement-policy RTL.
// Each macro needs signals named clk and rst_n in the module that uses it.
`ifndef SIGNATURE_RRIP_REPLACEMENT_STREAMING_TOP_ASSERT_SVH
`define SIGNATURE_RRIP_REPLACEMENT_STREAMING_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define SIGRRIP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sigrrip assertion failed");

// Check a property on every rising edge, reset included.
`define SIGRRIP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sigrrip assertion failed");

`else

`define SIGRRIP_ASSERT(lbl, prop)
`define SIGRRIP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### hw/rtl/sigrrip_pkg.sv
// Types and fixed constants of the signature-based RRIP replacement block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sigrrip_pkg;

    // Field widths of one item
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int BLK_W    = 32;
    localparam int SIG_W    = 6;
    localparam int AGE_W    = 2;
    localparam int CTR_W    = 2;
    localparam int OUT_W    = 4;

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;
    localparam int S_SET_LO  = 0;
    localparam int S_WAY_LO  = 11;
    localparam int S_BLK_LO  = 15;
    localparam int S_SIG_LO  = 47;
    localparam int S_HIT_BIT = 53;

    // Policy constants
    localparam logic [AGE_W-1:0] AGE_MAX  = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
    localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;
    localparam logic [SIG_W-1:0] SIG_MASK = 6'h3F;

    // Request kinds
    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic reduce;
        logic rd;
        logic upd_wr;
        logic age_wr;
        logic scan_init;
        logic scan_step;
        logic res_capture;
        logic res_from_scan;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_done;
        logic is_update;
        logic stream;
        logic scan_hit;
        logic scan_end;
    } sts_t;

endpackage

### hw/rtl/sigrrip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sigrrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sigrrip_ctrl.sv
// Sequencing state machine of the replacement block.
// Depends on sigrrip_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "signature_rrip_replacement_streaming_top_assert.svh"

module sigrrip_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output sigrrip_pkg::cmd_t  cmd,
    input  sigrrip_pkg::sts_t  sts
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_AGE    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.is_update)
                begin
                    cmd.upd_wr = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.stream)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.age_wr      = 1'b1;
                    cmd.res_capture = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    cmd.res_capture   = 1'b1;
                    cmd.res_from_scan = 1'b1;
                    state_next        = S_DONE;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_AGE;
                end
            end
            S_AGE:
            begin
                cmd.age_wr      = 1'b1;
                cmd.res_capture = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `SIGRRIP_ASSERT(a_accept_goes_reduce, (in_valid && in_ready) |=> (state_reg == S_REDUCE))
    `SIGRRIP_ASSERT(a_clear_once, (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
    `SIGRRIP_ASSERT(a_load_only_free, cmd.out_load |-> (!out_valid_reg || out_ready))
    `SIGRRIP_ASSERT_ALWAYS(a_no_result_in_clear, (state_reg == S_CLEAR) |-> !out_valid_reg)

endmodule

### hw/rtl/sigrrip_dp.sv
// Datapath: set-row and counter memories, detector, training and victim search.
// Depends on sigrrip_pkg, sigrrip_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "signature_rrip_replacement_streaming_top_assert.svh"

module sigrrip_dp #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int SIG_ENTRIES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sigrrip_pkg::cmd_t                     cmd,
    output sigrrip_pkg::sts_t                     sts,
    input  logic                                  req_type,
    input  logic [sigrrip_pkg::SET_IN_W-1:0]      set_index,
    input  logic [sigrrip_pkg::WAY_IN_W-1:0]      way,
    input  logic [sigrrip_pkg::BLK_W-1:0]         block_address,
    input  logic [sigrrip_pkg::SIG_W-1:0]         pc_signature,
    input  logic                                  hit,
    output logic [sigrrip_pkg::OUT_W-1:0]         victim_way
);

    localparam int AGE_W     = sigrrip_pkg::AGE_W;
    localparam int SIG_W     = sigrrip_pkg::SIG_W;
    localparam int BLK_W     = sigrrip_pkg::BLK_W;
    localparam int CTR_W     = sigrrip_pkg::CTR_W;
    localparam int SET_IN_W  = sigrrip_pkg::SET_IN_W;
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int SET_W     = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int SLOT_W    = $clog2(SIG_ENTRIES);
    localparam int SIG_LO    = NUM_WAYS * AGE_W;
    localparam int STR_BIT   = NUM_WAYS * (AGE_W + SIG_W);
    localparam int PREV_LO   = STR_BIT + 1;
    localparam int ROW_W     = PREV_LO + BLK_W;
    localparam int CLEAR_LEN = NUM_SETS > SIG_ENTRIES ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W     = CLEAR_LEN > 1 ? $clog2(CLEAR_LEN) : 1;

    // Remainder of a set number by NUM_SETS, by constant compare and subtract
    function automatic logic [SET_IN_W-1:0] rem_set(input logic [SET_IN_W-1:0] v);
        logic [SET_IN_W-1:0] r;
        r = v;
        for (int k = SET_IN_W - 1; k >= 0; k--)
        begin
            if ((NUM_SETS << k) < (1 << SET_IN_W))
            begin
                if (r >= SET_IN_W'(NUM_SETS << k))
                begin
                    r = r - SET_IN_W'(NUM_SETS << k);
                end
            end
        end
        return r;
    endfunction

    // Remainder of a signature by SIG_ENTRIES
    function automatic logic [SIG_W-1:0] rem_sig(input logic [SIG_W-1:0] v);
        logic [SIG_W-1:0] r;
        r = v;
        for (int k = SIG_W - 1; k >= 0; k--)
        begin
            if ((SIG_ENTRIES << k) < (1 << SIG_W))
            begin
                if (r >= SIG_W'(SIG_ENTRIES << k))
                begin
                    r = r - SIG_W'(SIG_ENTRIES << k);
                end
            end
        end
        return r;
    endfunction

    // Item registers
    logic                                req_reg;
    logic [SET_IN_W-1:0]                 set_in_reg;
    logic [sigrrip_pkg::WAY_IN_W-1:0]    way_in_reg;
    logic [BLK_W-1:0]                    blk_reg;
    logic [SIG_W-1:0]                    sig_reg;
    logic                                hit_reg;
    logic [SET_W-1:0]                    set_reg;
    logic [SLOT_W-1:0]                   slot_reg;

    // Clearing sweep, scan pipeline and result registers
    logic [CLR_W-1:0]                    clr_cnt_reg;
    logic [WAY_W-1:0]                    issue_idx_reg;
    logic                                chk_valid_reg;
    logic [WAY_W-1:0]                    chk_way_reg;
    logic [WAY_W-1:0]                    res_reg;
    logic [sigrrip_pkg::OUT_W-1:0]       out_reg;

    // Memory ports
    logic                                row_we;
    logic [SET_W-1:0]                    row_waddr;
    logic [ROW_W-1:0]                    row_wdata;
    logic [ROW_W-1:0]                    row_rdata;
    logic                                ctr_we;
    logic [SLOT_W-1:0]                   ctr_waddr;
    logic [CTR_W-1:0]                    ctr_wdata;
    logic                                ctr_re;
    logic [SLOT_W-1:0]                   ctr_raddr;
    logic [CTR_W-1:0]                    ctr_rdata;

    // Row views and derived values
    logic [AGE_W-1:0]                    age_cur [NUM_WAYS];
    logic [SIG_W-1:0]                    sig_cur [NUM_WAYS];
    logic [AGE_W-1:0]                    age_top;
    logic [AGE_W-1:0]                    lift;
    logic [WAY_W-1:0]                    age_victim;
    logic [ROW_W-1:0]                    row_aged;
    logic [ROW_W-1:0]                    row_upd;
    logic [ROW_W-1:0]                    row_clear;
    logic [BLK_W-1:0]                    prev_blk;
    logic [BLK_W-1:0]                    delta;
    logic                                strm_new;
    logic [CTR_W-1:0]                    ctr_new;
    logic [AGE_W-1:0]                    age_ins;
    logic                                way_ok;
    logic [WAY_W-1:0]                    way_idx;
    logic [WAY_W-1:0]                    issue_safe;
    logic                                clr_row_ok;
    logic                                clr_ctr_ok;

    // Capture the item and reduce its indices
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            set_in_reg <= set_index;
            way_in_reg <= way;
            blk_reg    <= block_address;
            sig_reg    <= pc_signature;
            hit_reg    <= hit;
        end
        if (cmd.reduce)
        begin
            set_reg  <= SET_W'(rem_set(set_in_reg));
            slot_reg <= SLOT_W'(rem_sig(sig_reg));
        end
    end

    // Split the row into ages and signatures
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            age_cur[w] = row_rdata[w * AGE_W +: AGE_W];
            sig_cur[w] = row_rdata[SIG_LO + w * SIG_W +: SIG_W];
        end
    end

    // Oldest age, aging lift and the lowest way that reaches the top
    always_comb
    begin
        logic has3;
        logic has2;
        logic has1;
        has3 = 1'b0;
        has2 = 1'b0;
        has1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            has3 = has3 | (age_cur[w] == 2'd3);
            has2 = has2 | (age_cur[w] == 2'd2);
            has1 = has1 | (age_cur[w] == 2'd1);
        end
        age_top = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
        lift    = sigrrip_pkg::AGE_MAX - age_top;
        age_victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (age_cur[w] == age_top)
            begin
                age_victim = WAY_W'(w);
            end
        end
        row_aged = row_rdata;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_aged[w * AGE_W +: AGE_W] = age_cur[w] + lift;
        end
    end

    // Streaming detector, counter training and the updated row
    assign prev_blk = row_rdata[PREV_LO +: BLK_W];
    assign delta    = blk_reg - prev_blk;
    assign way_ok   = (32'(way_in_reg) < NUM_WAYS);
    assign way_idx  = WAY_W'(way_in_reg);

    always_comb
    begin
        strm_new = row_rdata[STR_BIT];
        if (prev_blk != '0)
        begin
            if (delta == 32'd1 || delta == '1)
            begin
                strm_new = 1'b1;
            end
            else if (delta != '0)
            begin
                strm_new = 1'b0;
            end
        end

        ctr_new = ctr_rdata;
        if (hit_reg)
        begin
            if (ctr_rdata < sigrrip_pkg::CTR_MAX)
            begin
                ctr_new = ctr_rdata + 2'd1;
            end
        end
        else if (ctr_rdata != '0)
        begin
            ctr_new = ctr_rdata - 2'd1;
        end

        age_ins = sigrrip_pkg::AGE_MAX - ctr_new;
        if (strm_new && ctr_new <= 2'd1)
        begin
            age_ins = sigrrip_pkg::AGE_MAX;
        end

        row_upd                   = row_rdata;
        row_upd[STR_BIT]          = strm_new;
        row_upd[PREV_LO +: BLK_W] = blk_reg;
        if (way_ok)
        begin
            if (hit_reg)
            begin
                row_upd[int'(way_idx) * AGE_W +: AGE_W] = '0;
            end
            else
            begin
                row_upd[int'(way_idx) * AGE_W +: AGE_W] = age_ins;
                row_upd[SIG_LO + int'(way_idx) * SIG_W +: SIG_W] =
                    sig_reg & sigrrip_pkg::SIG_MASK;
            end
        end
    end

    // Row contents after reset: every age at the top, all else zero
    always_comb
    begin
        row_clear = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_clear[w * AGE_W +: AGE_W] = sigrrip_pkg::AGE_MAX;
        end
    end

    // Memory port selection
    assign clr_row_ok = cmd.clear_step && (32'(clr_cnt_reg) < NUM_SETS);
    assign clr_ctr_ok = cmd.clear_step && (32'(clr_cnt_reg) < SIG_ENTRIES);
    assign issue_safe = (32'(issue_idx_reg) < NUM_WAYS) ? issue_idx_reg : '0;

    assign row_we    = clr_row_ok || cmd.upd_wr || cmd.age_wr;
    assign row_waddr = cmd.clear_step ? clr_cnt_reg[SET_W-1:0] : set_reg;
    assign row_wdata = cmd.clear_step ? row_clear : (cmd.upd_wr ? row_upd : row_aged);

    assign ctr_we    = clr_ctr_ok || cmd.upd_wr;
    assign ctr_waddr = cmd.clear_step ? clr_cnt_reg[SLOT_W-1:0] : slot_reg;
    assign ctr_wdata = cmd.clear_step ? sigrrip_pkg::CTR_INIT : ctr_new;
    assign ctr_re    = cmd.rd || cmd.scan_step;
    assign ctr_raddr = cmd.scan_step ? SLOT_W'(rem_sig(sig_cur[issue_safe])) : slot_reg;

    sigrrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (cmd.rd),
        .raddr (set_reg),
        .rdata (row_rdata)
    );

    sigrrip_ram #(
        .WIDTH (CTR_W),
        .DEPTH (SIG_ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    // Clearing sweep and streaming scan pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            issue_idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            chk_way_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                issue_idx_reg <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
                chk_valid_reg <= 1'b1;
                chk_way_reg   <= issue_idx_reg;
            end
        end
    end

    // Result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_capture)
        begin
            res_reg <= cmd.res_from_scan ? chk_way_reg : age_victim;
        end
        if (cmd.out_load)
        begin
            out_reg <= sigrrip_pkg::OUT_W'(res_reg);
        end
    end

    assign victim_way = out_reg;

    // Status back to the controller
    assign sts.clear_done = (clr_cnt_reg == CLR_W'(CLEAR_LEN - 1));
    assign sts.is_update  = (req_reg == sigrrip_pkg::REQ_UPDATE);
    assign sts.stream     = row_rdata[STR_BIT];
    assign sts.scan_hit   = chk_valid_reg && (age_cur[chk_way_reg] == sigrrip_pkg::AGE_MAX)
                            && (ctr_rdata == '0);
    assign sts.scan_end   = chk_valid_reg && (chk_way_reg == WAY_W'(NUM_WAYS - 1));

    `SIGRRIP_ASSERT(a_chk_way_range, chk_valid_reg |-> (32'(chk_way_reg) < NUM_WAYS))

endmodule

### hw/rtl/signature_rrip_replacement_streaming_top.sv
// Top level of the signature-based RRIP replacement block with streaming detection.
// Depends on sigrrip_pkg, sigrrip_ctrl and sigrrip_dp.
`timescale 1ns / 1ps

// After reset the block sweeps its set-row and counter memories, one entry a
// cycle over max(NUM_SETS, SIG_ENTRIES) entries (2048 by default), and takes no
// item meanwhile. Afterwards it handles one item at a time. An update item
// returns nothing. A victim item returns one way; in a streaming set the
// counter table's single read port checks one way a cycle until a match or
// the last way. A result waiting in the output register does not stop the
// next item being taken.
module signature_rrip_replacement_streaming_top #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int SIG_ENTRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // set_index[10:0], way[14:11], block_address[46:15], pc_signature[52:47],
    // hit[53], zero fill [55:54]
    input  logic [sigrrip_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // victim_way[3:0], zero fill [7:4]
    output logic [sigrrip_pkg::M_TDATA_W-1:0] m_tdata
);

    sigrrip_pkg::cmd_t                cmd;
    sigrrip_pkg::sts_t                sts;
    logic [sigrrip_pkg::OUT_W-1:0]    victim_way;

    sigrrip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sigrrip_dp #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .SIG_ENTRIES (SIG_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (s_tuser[0]),
        .set_index     (s_tdata[sigrrip_pkg::S_SET_LO +: sigrrip_pkg::SET_IN_W]),
        .way           (s_tdata[sigrrip_pkg::S_WAY_LO +: sigrrip_pkg::WAY_IN_W]),
        .block_address (s_tdata[sigrrip_pkg::S_BLK_LO +: sigrrip_pkg::BLK_W]),
        .pc_signature  (s_tdata[sigrrip_pkg::S_SIG_LO +: sigrrip_pkg::SIG_W]),
        .hit           (s_tdata[sigrrip_pkg::S_HIT_BIT]),
        .victim_way    (victim_way)
    );

    // Pad the result to whole bytes
    assign m_tdata = sigrrip_pkg::M_TDATA_W'(victim_way);

endmodule

### test/tb_signature_rrip_replacement_streaming_top.sv
// Self-checking testbench for the signature-based RRIP replacement block.
// Depends on sigrrip_pkg and signature_rrip_replacement_streaming_top; holds its own
// model of the ages, signatures, reuse counters and streaming detector.
`timescale 1ns / 1ps

module tb_signature_rrip_replacement_streaming_top;

    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int SIG_ENTRIES  = 64;
    localparam int RANDOM_ITEMS = 430;
    localparam int HOT_SETS     = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic                             req;
        logic [sigrrip_pkg::SET_IN_W-1:0] set_idx;
        logic [sigrrip_pkg::WAY_IN_W-1:0] way;
        logic [sigrrip_pkg::BLK_W-1:0]    blk;
        logic [sigrrip_pkg::SIG_W-1:0]    sig;
        logic                             hit;
        logic                             typed;
        logic [sigrrip_pkg::OUT_W-1:0]    want;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [sigrrip_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]                        s_tuser = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [sigrrip_pkg::M_TDATA_W-1:0] m_tdata;

    // Typed expectation travelling alongside the item being offered
    logic                              row_typed = 1'b0;
    logic [sigrrip_pkg::OUT_W-1:0]     row_want = '0;

    // Shadow state of the replacement policy
    bit [sigrrip_pkg::AGE_W-1:0]  line_age_tab [0:NUM_SETS*NUM_WAYS-1];
    bit [sigrrip_pkg::SIG_W-1:0]  line_sig_tab [0:NUM_SETS*NUM_WAYS-1];
    bit [sigrrip_pkg::CTR_W-1:0]  reuse_tab    [0:SIG_ENTRIES-1];
    bit                           stream_tab   [0:NUM_SETS-1];
    bit [sigrrip_pkg::BLK_W-1:0]  last_blk_tab [0:NUM_SETS-1];

    logic [sigrrip_pkg::OUT_W-1:0] victim_ways_due [$];
    stim_row_t                     directed_rows [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  ready_hold = 0;
    bit  idle_on = 1'b0;

    signature_rrip_replacement_streaming_top #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .SIG_ENTRIES (SIG_ENTRIES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Pick a way to evict and age the set as the block does
    function automatic logic [sigrrip_pkg::OUT_W-1:0] choose_victim(input int set_idx);
        int   base;
        int   oldest;
        int   lift;
        bit   found;
        logic [sigrrip_pkg::OUT_W-1:0] pick;
        base   = set_idx * NUM_WAYS;
        found  = 1'b0;
        pick   = '0;
        oldest = 0;
        // streaming sets prefer a dead line whose signature never reuses
        if (stream_tab[set_idx])
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (!found && line_age_tab[base + w] == sigrrip_pkg::AGE_MAX &&
                    reuse_tab[line_sig_tab[base + w] % SIG_ENTRIES] == '0)
                begin
                    pick  = sigrrip_pkg::OUT_W'(w);
                    found = 1'b1;
                end
            end
        end
        if (!found)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
                if (int'(line_age_tab[base + w]) > oldest)
                    oldest = int'(line_age_tab[base + w]);
            lift = int'(sigrrip_pkg::AGE_MAX) - oldest;
            for (int w = 0; w < NUM_WAYS; w++)
                line_age_tab[base + w] = line_age_tab[base + w] + sigrrip_pkg::AGE_W'(lift);
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (!found && line_age_tab[base + w] == sigrrip_pkg::AGE_MAX)
                begin
                    pick  = sigrrip_pkg::OUT_W'(w);
                    found = 1'b1;
                end
            end
        end
        return pick;
    endfunction

    // Train detector and counters, then set the accessed line
    function automatic void train_access(input int set_idx, input int way,
                                         input logic [sigrrip_pkg::BLK_W-1:0] blk,
                                         input logic [sigrrip_pkg::SIG_W-1:0] sig,
                                         input logic hit);
        logic [sigrrip_pkg::BLK_W-1:0] prev;
        logic [sigrrip_pkg::BLK_W-1:0] delta;
        int                            slot;
        bit [sigrrip_pkg::CTR_W-1:0]   ctr;
        bit [sigrrip_pkg::AGE_W-1:0]   age;
        prev  = last_blk_tab[set_idx];
        delta = blk - prev;
        slot  = int'(sig) % SIG_ENTRIES;
        if (prev != '0)
        begin
            if (delta == 32'd1 || delta == 32'hFFFF_FFFF)
                stream_tab[set_idx] = 1'b1;
            else if (delta != '0)
                stream_tab[set_idx] = 1'b0;
        end
        last_blk_tab[set_idx] = blk;
        ctr = reuse_tab[slot];
        if (hit)
        begin
            if (ctr < sigrrip_pkg::CTR_MAX)
                ctr = ctr + 1'b1;
            reuse_tab[slot] = ctr;
            if (way < NUM_WAYS)
                line_age_tab[set_idx * NUM_WAYS + way] = '0;
        end
        else
        begin
            if (ctr > '0)
                ctr = ctr - 1'b1;
            reuse_tab[slot] = ctr;
            age = sigrrip_pkg::AGE_MAX - ctr;
            if (stream_tab[set_idx] && ctr <= 2'd1)
                age = sigrrip_pkg::AGE_MAX;
            if (way < NUM_WAYS)
            begin
                line_age_tab[set_idx * NUM_WAYS + way] = age;
                line_sig_tab[set_idx * NUM_WAYS + way] = sig & sigrrip_pkg::SIG_MASK;
            end
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // Follow both handshakes: predict on each accepted item, check each result
    always @(posedge clk)
    begin : watch_streams
        logic [sigrrip_pkg::OUT_W-1:0] predicted;
        logic [sigrrip_pkg::OUT_W-1:0] due;
        int                            set_sel;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                set_sel = int'(s_tdata[sigrrip_pkg::S_SET_LO +: sigrrip_pkg::SET_IN_W])
                          % NUM_SETS;
                if (s_tuser[0] == sigrrip_pkg::REQ_VICTIM)
                begin
                    predicted = choose_victim(set_sel);
                    victim_ways_due.push_back(row_typed ? row_want : predicted);
                end
                else
                begin
                    train_access(set_sel,
                                 int'(s_tdata[sigrrip_pkg::S_WAY_LO +: sigrrip_pkg::WAY_IN_W]),
                                 s_tdata[sigrrip_pkg::S_BLK_LO +: sigrrip_pkg::BLK_W],
                                 s_tdata[sigrrip_pkg::S_SIG_LO +: sigrrip_pkg::SIG_W],
                                 s_tdata[sigrrip_pkg::S_HIT_BIT]);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (victim_ways_due.size() == 0)
                    note_failure($sformatf("unexpected victim way %0d at cycle %0d",
                                           m_tdata[sigrrip_pkg::OUT_W-1:0], cycle_count));
                else
                begin
                    due = victim_ways_due.pop_front();
                    if (m_tdata[sigrrip_pkg::OUT_W-1:0] !== due)
                        note_failure($sformatf("victim_way: expected %0d, got %0d (cycle %0d)",
                                               due, m_tdata[sigrrip_pkg::OUT_W-1:0],
                                               cycle_count));
                end
            end
        end
    end

    // Result side: stall in short random bursts while idling is on
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input stim_row_t row);
        s_tdata   <= {2'b00, row.hit, row.sig, row.blk, row.way, row.set_idx};
        s_tuser   <= row.req;
        row_typed <= row.typed;
        row_want  <= row.want;
        s_tvalid  <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic stim_row_t make_row(input logic req, input int set_idx, input int way,
                                           input logic [sigrrip_pkg::BLK_W-1:0] blk,
                                           input int sig, input logic hit,
                                           input logic typed, input int want);
        stim_row_t row;
        row.req     = req;
        row.set_idx = sigrrip_pkg::SET_IN_W'(set_idx);
        row.way     = sigrrip_pkg::WAY_IN_W'(way);
        row.blk     = blk;
        row.sig     = sigrrip_pkg::SIG_W'(sig);
        row.hit     = hit;
        row.typed   = typed;
        row.want    = sigrrip_pkg::OUT_W'(want);
        return row;
    endfunction

    initial
    begin
        int                            hot_set [HOT_SETS];
        logic [sigrrip_pkg::BLK_W-1:0] hot_blk [HOT_SETS];
        logic [sigrrip_pkg::SIG_W-1:0] sig_pool [4];
        stim_row_t                     row;
        int                            pick;
        int                            slot;
        int                            step;

        // Bring the shadow state to its reset values
        for (int i = 0; i < NUM_SETS * NUM_WAYS; i++)
        begin
            line_age_tab[i] = sigrrip_pkg::AGE_MAX;
            line_sig_tab[i] = '0;
        end
        for (int i = 0; i < SIG_ENTRIES; i++)
            reuse_tab[i] = sigrrip_pkg::CTR_INIT;
        for (int i = 0; i < NUM_SETS; i++)
        begin
            stream_tab[i]   = 1'b0;
            last_blk_tab[i] = '0;
        end

        // Directed rows: extremes, streaming entry and exit, counter saturation
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 0, 0, 32'h0, 0,
                                         1'b0, 1'b1, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 2047, 15, 32'hFFFF_FFFF, 63,
                                         1'b1, 1'b1, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 2047, 15, 32'hFFFF_FFFF, 63,
                                         1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 2047, 0, 32'h0, 0,
                                         1'b0, 1'b1, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 3, 0, 32'h40, 0,
                                         1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 3, 0, 32'h0, 0,
                                         1'b0, 1'b1, 1));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 7, 2, 32'd100, 9,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 7, 5, 32'd101, 9,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 7, 0, 32'h0, 0,
                                         1'b0, 1'b1, 2));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 7, 2, 32'd101, 20,
                                         1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 7, 0, 32'h0, 0,
                                         1'b0, 1'b1, 5));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 7, 9, 32'd100, 9,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 7, 0, 32'h0, 0,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 7, 6, 32'h12345, 30,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 7, 0, 32'h0, 0,
                                         1'b0, 1'b1, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 9, 3, 32'h0, 1,
                                         1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 9, 4, 32'hFFFF_FFFF, 1,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 9, 1, 32'h0, 2,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 9, 0, 32'h0, 0,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 11, 0, 32'h800, 63,
                                         1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 11, 1, 32'h900, 63,
                                         1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_UPDATE, 11, 2, 32'hA00, 63,
                                         1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(sigrrip_pkg::REQ_VICTIM, 11, 0, 32'h0, 0,
                                         1'b0, 1'b0, 0));

        // Hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // Random part centred on a few hot sets and signatures
        for (int i = 0; i < HOT_SETS; i++)
        begin
            hot_set[i] = $urandom_range(0, NUM_SETS - 1);
            hot_blk[i] = $urandom;
        end
        for (int i = 0; i < 4; i++)
            sig_pool[i] = sigrrip_pkg::SIG_W'($urandom_range(0, 63));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (n >= RANDOM_ITEMS - 50)
                idle_on = 1'b0;

            // Drain once mid-run before offering more
            if (n == RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (victim_ways_due.size() != 0)
                    @(posedge clk);
            end

            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, HOT_SETS - 1);
            row  = make_row(1'($urandom_range(0, 1)), $urandom_range(0, NUM_SETS - 1),
                            $urandom_range(0, 15), $urandom, $urandom_range(0, 63),
                            1'($urandom_range(0, 1)), 1'b0, 0);
            if (pick >= 12 && pick < 50)
            begin
                row.req     = sigrrip_pkg::REQ_VICTIM;
                row.set_idx = sigrrip_pkg::SET_IN_W'(hot_set[slot]);
            end
            else if (pick >= 50)
            begin
                row.req     = sigrrip_pkg::REQ_UPDATE;
                row.set_idx = sigrrip_pkg::SET_IN_W'(hot_set[slot]);
                step = $urandom_range(0, 9);
                if (step <= 3)
                    row.blk = hot_blk[slot] + 32'd1;
                else if (step <= 5)
                    row.blk = hot_blk[slot] - 32'd1;
                else if (step == 6)
                    row.blk = hot_blk[slot];
                hot_blk[slot] = row.blk;
                if ($urandom_range(0, 4) != 0)
                    row.sig = sig_pool[$urandom_range(0, 3)];
            end
            send_item(row);

            // Sender gap
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        // Wait for outstanding results, then let the block settle
        @(posedge clk);
        while (victim_ways_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && victim_ways_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
